@@ sv/tts_pkg.sv @@
// Shared types and constants of the periodic task tick scheduler.
`timescale 1ns / 1ps
package tts_pkg;

	localparam int TICK_W    = 32;
	localparam int PER_W     = 16;
	localparam int OFF_W     = 8;
	localparam int SLOT_FW   = 4;
	localparam int FUNC_W    = 3;
	localparam int DUE_W     = 10;
	localparam int EPT_W     = 16;
	localparam int MOD_CNT_W = $clog2(TICK_W);

	// stream payload widths
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 48;

	typedef enum logic [FUNC_W-1:0] {
		FN_TIMER   = 3'd0,
		FN_CREATE  = 3'd1,
		FN_SUSPEND = 3'd2,
		FN_RESUME  = 3'd3,
		FN_DELETE  = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		RS_EMPTY     = 2'd0,
		RS_READY     = 2'd1,
		RS_SUSPENDED = 2'd2,
		RS_KILLED    = 2'd3
	} run_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_START = 2'd1,
		ST_WAIT  = 2'd2,
		ST_DONE  = 2'd3
	} state_t;

	// command towards the task table
	typedef struct packed {
		logic               valid;
		logic [FUNC_W-1:0]  func;
		logic [SLOT_FW-1:0] slot;
		logic [PER_W-1:0]   period;
		logic [OFF_W-1:0]   offset;
	} cmd_t;

	// status from the serial modulo unit
	typedef struct packed {
		logic done;
		logic zero;
	} mod_stat_t;

endpackage

@@ sv/tts_mod_unit.sv @@
// Bit-serial restoring modulo unit: tick count modulo task period.
`timescale 1ns / 1ps
module tts_mod_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tts_pkg::TICK_W-1:0] dividend,
	input  logic [tts_pkg::PER_W-1:0]  divisor,
	output tts_pkg::mod_stat_t         stat
);
	import tts_pkg::*;

	localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(TICK_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [TICK_W-1:0]    div_q;
	logic [PER_W-1:0]     per_q;
	logic [PER_W-1:0]     rem_q;
	logic [PER_W:0]       trial;
	logic                 fits;
	logic [PER_W-1:0]     rem_nxt;

	// one quotient bit per cycle: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial   = {rem_q, div_q[TICK_W-1]};
		fits    = trial >= {1'b0, per_q};
		rem_nxt = fits ? PER_W'(trial - {1'b0, per_q}) : trial[PER_W-1:0];
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == MOD_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MOD_LAST)
					busy_q <= 1'b0;
			end
		end
	end

	// shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			per_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			div_q <= {div_q[TICK_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign stat.done = done_q;
	assign stat.zero = (rem_q == '0);

endmodule

@@ sv/tts_task_table.sv @@
// Task table: slot state, period and offset, with command decode.
`timescale 1ns / 1ps
module tts_task_table #(
	parameter int TASK_SLOTS = 10,
	parameter int SLOT_W     = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tts_pkg::cmd_t              cmd,
	output logic                       cmd_ok,
	input  logic [SLOT_W-1:0]          rd_idx,
	output logic                       rd_elig,
	output logic [tts_pkg::PER_W-1:0]  rd_period,
	output logic [tts_pkg::OFF_W-1:0]  rd_offset
);
	import tts_pkg::*;

	logic             live_q   [0:TASK_SLOTS-1];
	run_t             state_q  [0:TASK_SLOTS-1];
	logic [PER_W-1:0] period_q [0:TASK_SLOTS-1];
	logic [OFF_W-1:0] offset_q [0:TASK_SLOTS-1];

	logic              in_range;
	logic [SLOT_W-1:0] wr_idx;
	logic              do_create;
	logic              do_suspend;
	logic              do_resume;
	logic              do_delete;

	// command decode
	always_comb begin
		in_range   = {1'b0, cmd.slot} < (SLOT_FW + 1)'(TASK_SLOTS);
		wr_idx     = SLOT_W'(cmd.slot);
		do_create  = 1'b0;
		do_suspend = 1'b0;
		do_resume  = 1'b0;
		do_delete  = 1'b0;
		unique case (func_t'(cmd.func))
			FN_CREATE:  do_create  = in_range && (cmd.period != '0);
			FN_SUSPEND: do_suspend = in_range;
			FN_RESUME:  do_resume  = in_range && (state_q[wr_idx] == RS_SUSPENDED);
			FN_DELETE:  do_delete  = in_range;
			default:    ;
		endcase
		cmd_ok = do_create || do_suspend || do_resume || do_delete;
	end

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				live_q[i]  <= 1'b0;
				state_q[i] <= RS_EMPTY;
			end
		end else if (cmd.valid) begin
			if (do_create) begin
				live_q[wr_idx]  <= 1'b1;
				state_q[wr_idx] <= RS_READY;
			end
			if (do_suspend)
				state_q[wr_idx] <= RS_SUSPENDED;
			if (do_resume)
				state_q[wr_idx] <= RS_READY;
			if (do_delete) begin
				live_q[wr_idx]  <= 1'b0;
				state_q[wr_idx] <= RS_KILLED;
			end
		end
	end

	// period and offset, valid once a create has written them
	always_ff @(posedge clk) begin
		if (cmd.valid && do_create) begin
			period_q[wr_idx] <= cmd.period;
			offset_q[wr_idx] <= cmd.offset;
		end
	end

	// sweep read port
	assign rd_elig   = live_q[rd_idx] && (state_q[rd_idx] == RS_READY);
	assign rd_period = period_q[rd_idx];
	assign rd_offset = offset_q[rd_idx];

endmodule

@@ sv/periodic_task_tick_scheduler.sv @@
// Top level of the periodic task tick scheduler.
//
//  channel  | signals                              | direction | contents
//  s_       | s_tvalid s_tready s_tdata s_tuser    | in        | one command or timer event
//  m_       | m_tvalid m_tready m_tdata            | out       | one result per input item
//  cfg_     | cfg_valid cfg_ready cfg_data         | in        | events_per_tick write
//
// Commands and timer events that do not finish a tick go straight to the done state.
// A finished tick sweeps the slots in turn through one bit-serial modulo unit.
// Reset clears the task table state, tick count and countdown; no clearing pass is needed.
// One item at a time; a new item is taken while the previous result waits on m_.
`timescale 1ns / 1ps
module periodic_task_tick_scheduler #(
	parameter int TASK_SLOTS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [3:0] slot, [19:4] period, [27:20] start_offset, [31:28] zero
	input  logic [tts_pkg::S_DATA_W-1:0] s_tdata,
	// [2:0] func
	input  logic [tts_pkg::FUNC_W-1:0]   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [0] tick_advanced, [10:1] due_mask, [42:11] tick_value, [43] accepted, [47:44] zero
	output logic [tts_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tts_pkg::EPT_W-1:0]    cfg_data
);
	import tts_pkg::*;

	localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TASK_SLOTS - 1);

	state_t             state_q;
	state_t             state_nxt;
	logic [SLOT_W-1:0]  idx_q;
	logic [EPT_W-1:0]   ept_q;
	logic [EPT_W-1:0]   countdown_q;
	logic [TICK_W-1:0]  tick_q;
	logic [DUE_W-1:0]   due_q;
	logic               res_adv_q;
	logic               res_acc_q;
	logic               m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	logic               s_accept;
	logic               mod_start;
	logic               load_out;
	logic [EPT_W-1:0]   cd_dec;
	logic               expire;
	logic               is_timer;
	cmd_t               cmd;
	logic               cmd_ok;
	logic               rd_elig;
	logic [PER_W-1:0]   rd_period;
	logic [OFF_W-1:0]   rd_offset;
	mod_stat_t          mstat;
	logic               tick_ge;
	logic               tick_eq;
	logic               hit;

	assign s_accept = s_tvalid && s_tready;
	assign is_timer = (func_t'(s_tuser) == FN_TIMER);
	assign cd_dec   = countdown_q - 1'b1;
	assign expire   = (cd_dec == '0);

	assign cmd.valid  = s_accept;
	assign cmd.func   = s_tuser;
	assign cmd.slot   = s_tdata[SLOT_FW-1:0];
	assign cmd.period = s_tdata[SLOT_FW +: PER_W];
	assign cmd.offset = s_tdata[SLOT_FW + PER_W +: OFF_W];

	tts_task_table #(
		.TASK_SLOTS (TASK_SLOTS),
		.SLOT_W     (SLOT_W)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_ok    (cmd_ok),
		.rd_idx    (idx_q),
		.rd_elig   (rd_elig),
		.rd_period (rd_period),
		.rd_offset (rd_offset)
	);

	tts_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (tick_q),
		.divisor  (rd_period),
		.stat     (mstat)
	);

	// due test for the slot under the sweep
	always_comb begin
		tick_ge = (tick_q[TICK_W-1:OFF_W] != '0) || (tick_q[OFF_W-1:0] >= rd_offset);
		tick_eq = (tick_q[TICK_W-1:OFF_W] == '0) && (tick_q[OFF_W-1:0] == rd_offset);
		hit     = rd_elig && ((mstat.zero && tick_ge) || tick_eq);
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// next state and strobes
	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		mod_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_nxt = (is_timer && expire) ? ST_START : ST_DONE;
			end
			ST_START: begin
				mod_start = 1'b1;
				state_nxt = ST_WAIT;
			end
			ST_WAIT: begin
				if (mstat.done)
					state_nxt = (idx_q == SLOT_LAST) ? ST_DONE : ST_START;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// tick count, countdown, events_per_tick register, sweep index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ept_q       <= EPT_W'(1);
			countdown_q <= EPT_W'(1);
			tick_q      <= '0;
			idx_q       <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				ept_q       <= cfg_data;
				countdown_q <= cfg_data;
			end else if (s_accept && is_timer) begin
				if (expire) begin
					tick_q      <= tick_q + 1'b1;
					countdown_q <= ept_q;
				end else begin
					countdown_q <= cd_dec;
				end
			end
			if (s_accept)
				idx_q <= '0;
			else if (state_q == ST_WAIT && mstat.done && idx_q != SLOT_LAST)
				idx_q <= idx_q + 1'b1;
			if (load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// result collection and output register
	always_ff @(posedge clk) begin
		if (s_accept) begin
			due_q     <= '0;
			res_adv_q <= is_timer && expire;
			res_acc_q <= is_timer || cmd_ok;
		end else if (state_q == ST_WAIT && mstat.done) begin
			for (int i = 0; i < DUE_W; i++) begin
				if ({1'b0, idx_q} == (SLOT_W + 1)'(i) && i < TASK_SLOTS && hit)
					due_q[i] <= 1'b1;
			end
		end
		if (load_out)
			m_tdata_q <= {(M_DATA_W - TICK_W - DUE_W - 2)'(0), res_acc_q, tick_q, due_q,
				res_adv_q};
	end

	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign cfg_ready = 1'b1;

endmodule

@@ sv/tts_checker.sv @@
// Port-level checks for the periodic task tick scheduler, bound to the top level.
`timescale 1ns / 1ps
module tts_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [tts_pkg::M_DATA_W-1:0] m_tdata
);
	import tts_pkg::*;

	// a stalled result keeps its transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item in flight: input closes after each transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in work");

	// a finished tick is always an accepted timer event
	a_adv_acc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[DUE_W + TICK_W + 1])
		else $error("tick advanced without acceptance");

	// due slots only on a finished tick
	a_due_tick: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[DUE_W:1] != '0) |-> m_tdata[0])
		else $error("due mask without tick");

endmodule

bind periodic_task_tick_scheduler tts_checker u_tts_checker (.*);
